### design/gbnq_pkg.sv
// package for the grid bitset neighbour query block
package gbnq_pkg;

  localparam int unsigned MAX_CELLS      = 64;
  localparam int unsigned WORD_BITS      = 64;
  localparam int unsigned WORDS_PER_CELL = 4;
  localparam int unsigned MAX_HITS       = 16;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_RANGE_LOW  = 2'd0,
    CFG_RANGE_HIGH = 2'd1,
    CFG_RESOLUTION = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIVX,
    ST_DIVY,
    ST_DIVR,
    ST_INS_RD,
    ST_INS_WR,
    ST_RD,
    ST_WAIT,
    ST_SCAN,
    ST_EMPTY,
    ST_FLUSH
  } state_e;

endpackage

### design/grid_bitset_neighbour_query.sv
// top level of the grid bitset neighbour query block
//
// After reset the block runs a clearing pass over both stores, one memory row a cycle,
// and holds busy high through it; a clear item runs the same pass. An insert inside
// the range runs two 40-step restoring divisions (one quotient bit a cycle) for the
// cell of x and y, then a read and a write of the row and column stores. A query runs
// three such divisions (x, y, reach), then for each scanned cell and word a memory
// read, a wait for the read data and a check of the ANDed word, which also sends its
// hits one by one; ST_FLUSH or ST_EMPTY gives the last result, and the scan stops
// early once MAX_HITS hits are found. A query centre outside the range goes from
// ST_DIVX straight to ST_EMPTY, a not-found answer. busy is high from the cycle after
// start of a clear, insert or query until it is done, for a query until its last result
// has gone out; each result shows for exactly one cycle on valid_o and cannot be
// held off. The stores are two synchronous memories with a registered read port;
// the block does one item at a time, so no read and write of the same entry overlap.
module grid_bitset_neighbour_query #(
  parameter int unsigned MAX_CELLS      = gbnq_pkg::MAX_CELLS,
  parameter int unsigned WORD_BITS      = gbnq_pkg::WORD_BITS,
  parameter int unsigned WORDS_PER_CELL = gbnq_pkg::WORDS_PER_CELL,
  parameter int unsigned MAX_HITS       = gbnq_pkg::MAX_HITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [7:0]  agent_index_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic [30:0] radius_i,
  output logic        valid_o,
  output logic [7:0]  hit_agent_o,
  output logic        found_o,
  output logic        last_o
);

  localparam int unsigned DEPTH = MAX_CELLS * WORDS_PER_CELL;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned WW    = (WORDS_PER_CELL > 1) ? $clog2(WORDS_PER_CELL) : 1;
  localparam int unsigned BW    = $clog2(WORD_BITS);
  localparam int unsigned RESW  = $clog2(MAX_CELLS + 1);
  localparam int unsigned HW    = $clog2(MAX_HITS + 1);
  localparam int unsigned AGW   = WW + BW;
  localparam int unsigned NUMW  = 33 + RESW;   // dividend width
  localparam int unsigned DENW  = 33;          // divisor width
  localparam int unsigned DCW   = $clog2(NUMW + 1);

  // configuration
  logic signed [31:0] range_low_q, range_high_q;
  logic [6:0]         resolution_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= 32'sd0;
      range_high_q <= 32'sd4194304;
      resolution_q <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gbnq_pkg::CFG_RANGE_LOW:  range_low_q  <= cfg_data_i;
        gbnq_pkg::CFG_RANGE_HIGH: range_high_q <= cfg_data_i;
        gbnq_pkg::CFG_RESOLUTION: resolution_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // effective resolution and grid size
  logic [RESW-1:0]  res_eff;
  logic signed [32:0] size_s;
  logic [DENW-1:0]  size_u;
  always_comb begin
    if (resolution_q == 7'd0) res_eff = RESW'(1);
    else if (32'(resolution_q) > MAX_CELLS) res_eff = RESW'(MAX_CELLS);
    else res_eff = RESW'(resolution_q);
    size_s = 33'(range_high_q) - 33'(range_low_q);
    size_u = DENW'(size_s);
  end

  // latched item
  gbnq_pkg::action_e  act_q;
  logic [7:0]         agent_q;
  logic signed [31:0] px_q, py_q;
  logic [30:0]        rad_q;

  // inside-range checks
  logic in_x, in_y;
  assign in_x = (size_s > 0) && (px_q >= range_low_q) && (px_q < range_high_q);
  assign in_y = (size_s > 0) && (py_q >= range_low_q) && (py_q < range_high_q);

  // shared restoring divider, one quotient bit a cycle
  logic [NUMW-1:0] dnum_q, dnum_d;
  logic [DENW:0]   drem_q, drem_d;
  logic [DCW-1:0]  dcnt_q;
  logic [DENW:0]   dtrial;
  logic            dgo, ddone;
  logic [NUMW-1:0] dnum_load;

  assign dtrial = {drem_q[DENW-1:0], dnum_q[NUMW-1]} - {1'b0, size_u};
  always_comb begin
    if (!dtrial[DENW]) begin
      drem_d = dtrial;
      dnum_d = {dnum_q[NUMW-2:0], 1'b1};
    end else begin
      drem_d = {drem_q[DENW-1:0], dnum_q[NUMW-1]};
      dnum_d = {dnum_q[NUMW-2:0], 1'b0};
    end
  end
  assign ddone = (dcnt_q == DCW'(NUMW));

  // cell results
  logic [CW-1:0]   cx_q, cy_q;
  logic [RESW-1:0] reach_q;
  logic [CW-1:0]   quo_cell;
  always_comb begin
    if (dnum_q > NUMW'(res_eff - RESW'(1))) quo_cell = CW'(res_eff - RESW'(1));
    else quo_cell = CW'(dnum_q);
  end

  // scan bounds
  logic [CW-1:0] x0, x1, y0, y1;
  always_comb begin
    logic [RESW:0] hx, hy, rmax;
    rmax = {1'b0, res_eff} - (RESW+1)'(1);
    x0 = ({1'b0, reach_q} > (RESW+1)'(cx_q)) ? '0 : CW'((RESW+1)'(cx_q) - reach_q);
    y0 = ({1'b0, reach_q} > (RESW+1)'(cy_q)) ? '0 : CW'((RESW+1)'(cy_q) - reach_q);
    hx = (RESW+1)'(cx_q) + reach_q;
    hy = (RESW+1)'(cy_q) + reach_q;
    x1 = (hx > rmax) ? CW'(rmax) : CW'(hx);
    y1 = (hy > rmax) ? CW'(rmax) : CW'(hy);
  end

  // memories
  logic [WORD_BITS-1:0] row_mem [DEPTH];
  logic [WORD_BITS-1:0] col_mem [DEPTH];
  logic [WORD_BITS-1:0] row_rd_q, col_rd_q;
  logic [AW-1:0]        row_ra, col_ra, row_wa, col_wa;
  logic [WORD_BITS-1:0] row_wd, col_wd;
  logic                 mem_we, mem_re;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem[row_wa] <= row_wd;
      col_mem[col_wa] <= col_wd;
    end
    if (mem_re) begin
      row_rd_q <= row_mem[row_ra];
      col_rd_q <= col_mem[col_ra];
    end
  end

  // control
  gbnq_pkg::state_e state_q, state_d;
  logic [AW-1:0]        clr_q;
  logic [CW-1:0]        sx_q, sy_q;
  logic [WW-1:0]        sw_q;
  logic [HW-1:0]        nhit_q;
  logic [WORD_BITS-1:0] both_q;
  logic                 pend_q;      // a found result waits for its last flag
  logic [7:0]           pend_agent_q;
  logic                 scan_end;    // current cell/word is the final one
  logic [WW-1:0]        agent_w;
  logic [BW-1:0]        agent_b;
  logic [BW-1:0]        low_bit;
  logic                 word_ok;

  assign agent_w = WW'(agent_q >> BW);
  assign agent_b = BW'(agent_q);
  assign word_ok = (32'(agent_q) >> BW) < WORDS_PER_CELL;

  always_comb begin
    low_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (both_q[i]) low_bit = BW'(i);
    end
  end

  assign scan_end = (sx_q == x1) && (sy_q == y1) && (32'(sw_q) == WORDS_PER_CELL - 1);
  assign busy = (state_q != gbnq_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gbnq_pkg::ST_IDLE: begin
        if (start) begin
          unique case (gbnq_pkg::action_e'(action_i))
            gbnq_pkg::ACT_CLEAR:  state_d = gbnq_pkg::ST_CLEAR;
            gbnq_pkg::ACT_INSERT,
            gbnq_pkg::ACT_QUERY:  state_d = gbnq_pkg::ST_DIVX;
            default:              state_d = gbnq_pkg::ST_IDLE;
          endcase
        end
      end
      gbnq_pkg::ST_CLEAR:
        if (32'(clr_q) == DEPTH - 1) state_d = gbnq_pkg::ST_IDLE;
      gbnq_pkg::ST_DIVX: begin
        if (act_q == gbnq_pkg::ACT_INSERT && (!word_ok || !in_x || !in_y))
          state_d = gbnq_pkg::ST_IDLE;
        else if (act_q == gbnq_pkg::ACT_QUERY && (!in_x || !in_y))
          state_d = gbnq_pkg::ST_EMPTY;
        else if (ddone) state_d = gbnq_pkg::ST_DIVY;
      end
      gbnq_pkg::ST_DIVY:
        if (ddone) state_d = (act_q == gbnq_pkg::ACT_INSERT) ? gbnq_pkg::ST_INS_RD
                                                              : gbnq_pkg::ST_DIVR;
      gbnq_pkg::ST_DIVR:  if (ddone) state_d = gbnq_pkg::ST_RD;
      gbnq_pkg::ST_INS_RD: state_d = gbnq_pkg::ST_INS_WR;
      gbnq_pkg::ST_INS_WR: state_d = gbnq_pkg::ST_IDLE;
      gbnq_pkg::ST_RD:     state_d = gbnq_pkg::ST_WAIT;
      gbnq_pkg::ST_WAIT:   state_d = gbnq_pkg::ST_SCAN;
      gbnq_pkg::ST_SCAN: begin
        if (both_q != '0) begin
          if (32'(nhit_q) + 1 >= MAX_HITS) state_d = gbnq_pkg::ST_FLUSH;
        end else if (scan_end) begin
          state_d = (pend_q) ? gbnq_pkg::ST_FLUSH : gbnq_pkg::ST_EMPTY;
        end else begin
          state_d = gbnq_pkg::ST_RD;
        end
      end
      gbnq_pkg::ST_EMPTY: state_d = gbnq_pkg::ST_IDLE;
      gbnq_pkg::ST_FLUSH: state_d = gbnq_pkg::ST_IDLE;
      default:            state_d = gbnq_pkg::ST_IDLE;
    endcase
  end

  // memory control and divider operand selection
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    row_ra = AW'(32'(cx_q) * WORDS_PER_CELL + 32'(agent_w));
    col_ra = AW'(32'(cy_q) * WORDS_PER_CELL + 32'(agent_w));
    row_wa = row_ra;
    col_wa = col_ra;
    row_wd = row_rd_q | (WORD_BITS'(1) << agent_b);
    col_wd = col_rd_q | (WORD_BITS'(1) << agent_b);
    dgo    = 1'b0;
    dnum_load = '0;
    unique case (state_q)
      gbnq_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        row_wa = clr_q;
        col_wa = clr_q;
        row_wd = '0;
        col_wd = '0;
      end
      gbnq_pkg::ST_INS_RD: mem_re = 1'b1;
      gbnq_pkg::ST_INS_WR: mem_we = 1'b1;
      gbnq_pkg::ST_RD: begin
        mem_re = 1'b1;
        row_ra = AW'(32'(sx_q) * WORDS_PER_CELL + 32'(sw_q));
        col_ra = AW'(32'(sy_q) * WORDS_PER_CELL + 32'(sw_q));
      end
      default: ;
    endcase
    if (state_q == gbnq_pkg::ST_DIVX && ddone) begin
      dgo = 1'b1;
      dnum_load = NUMW'(33'(py_q) - 33'(range_low_q)) * NUMW'(res_eff);
    end else if (state_q == gbnq_pkg::ST_DIVY && ddone) begin
      dgo = 1'b1;
      dnum_load = NUMW'(rad_q) * NUMW'(res_eff);
    end
  end

  // outputs
  always_comb begin
    valid_o     = 1'b0;
    hit_agent_o = pend_agent_q;
    found_o     = 1'b1;
    last_o      = 1'b0;
    unique case (state_q)
      gbnq_pkg::ST_SCAN: begin
        valid_o = pend_q && (both_q != '0);
      end
      gbnq_pkg::ST_FLUSH: begin
        valid_o = 1'b1;
        last_o  = 1'b1;
      end
      gbnq_pkg::ST_EMPTY: begin
        valid_o     = 1'b1;
        hit_agent_o = '0;
        found_o     = 1'b0;
        last_o      = 1'b1;
      end
      default: ;
    endcase
  end

  // registers, reset starts the clearing pass over both stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbnq_pkg::ST_CLEAR;
      clr_q   <= '0;
      dcnt_q  <= '0;
      pend_q  <= 1'b0;
      nhit_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == gbnq_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
      else clr_q <= '0;
      if (state_q == gbnq_pkg::ST_IDLE || dgo) dcnt_q <= '0;
      else if (!ddone) dcnt_q <= dcnt_q + DCW'(1);
      if (state_q == gbnq_pkg::ST_IDLE) begin
        pend_q <= 1'b0;
        nhit_q <= '0;
      end else if (state_q == gbnq_pkg::ST_SCAN && both_q != '0) begin
        pend_q <= 1'b1;
        nhit_q <= nhit_q + HW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == gbnq_pkg::ST_IDLE && start) begin
      act_q   <= gbnq_pkg::action_e'(action_i);
      agent_q <= agent_index_i;
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
      rad_q   <= radius_i;
      dnum_q  <= NUMW'(33'(pos_x_i) - 33'(range_low_q)) * NUMW'(res_eff);
      drem_q  <= '0;
    end else if (dgo) begin
      dnum_q <= dnum_load;
      drem_q <= '0;
    end else if (!ddone) begin
      dnum_q <= dnum_d;
      drem_q <= drem_d;
    end
    if (ddone) begin
      if (state_q == gbnq_pkg::ST_DIVX) cx_q <= quo_cell;
      if (state_q == gbnq_pkg::ST_DIVY) cy_q <= quo_cell;
      if (state_q == gbnq_pkg::ST_DIVR) begin
        reach_q <= (dnum_q > NUMW'(res_eff)) ? res_eff : RESW'(dnum_q);
      end
    end
    if (state_q == gbnq_pkg::ST_DIVR && ddone) begin
      sw_q <= '0;
    end
    if (state_q == gbnq_pkg::ST_WAIT) both_q <= row_rd_q & col_rd_q;
    if (state_q == gbnq_pkg::ST_SCAN) begin
      if (both_q != '0) begin
        both_q       <= both_q & ~(WORD_BITS'(1) << low_bit);
        pend_agent_q <= 8'({sw_q, low_bit});
      end else if (32'(sw_q) == WORDS_PER_CELL - 1) begin
        sw_q <= '0;
        if (sy_q == y1) begin
          sy_q <= y0;
          sx_q <= sx_q + CW'(1);
        end else begin
          sy_q <= sy_q + CW'(1);
        end
      end else begin
        sw_q <= sw_q + WW'(1);
      end
    end
    if (state_q == gbnq_pkg::ST_DIVR && ddone) begin
      sx_q <= ({1'b0, (dnum_q > NUMW'(res_eff)) ? res_eff : RESW'(dnum_q)} >
               (RESW+1)'(cx_q)) ? '0 :
              CW'((RESW+1)'(cx_q) - ((dnum_q > NUMW'(res_eff)) ? res_eff : RESW'(dnum_q)));
      sy_q <= ({1'b0, (dnum_q > NUMW'(res_eff)) ? res_eff : RESW'(dnum_q)} >
               (RESW+1)'(cy_q)) ? '0 :
              CW'((RESW+1)'(cy_q) - ((dnum_q > NUMW'(res_eff)) ? res_eff : RESW'(dnum_q)));
    end
  end

  logic unused_agw;
  assign unused_agw = (AGW == 0) && (x0 == x1);

endmodule

### tb/sv/grid_bitset_neighbour_query_test.sv
// self-checking testbench for the grid bitset neighbour query block
module grid_bitset_neighbour_query_test;
  timeunit 1ns;
  timeprecision 1ps;

  // cycle limit, far above the slowest legal run (every item a full-grid query)
  localparam longint CYCLE_LIMIT = 60_000_000;
  // a clear walks the whole store, so wait out at least that before config writes
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [7:0] hit_agent;
    logic       found;
    logic       last;
  } hit_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action_i = '0;
  logic [7:0]  agent_index_i = '0;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic [30:0] radius_i = '0;
  logic        valid_o;
  logic [7:0]  hit_agent_o;
  logic        found_o;
  logic        last_o;

  grid_bitset_neighbour_query i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start, .busy,
    .action_i, .agent_index_i, .pos_x_i, .pos_y_i, .radius_i,
    .valid_o, .hit_agent_o, .found_o, .last_o
  );

  // local copy of the block's registers and bitmap stores
  longint      grid_lo;
  longint      grid_hi;
  logic [6:0]  grid_res;
  logic [63:0] row_bits [gbnq_pkg::MAX_CELLS*gbnq_pkg::WORDS_PER_CELL];
  logic [63:0] col_bits [gbnq_pkg::MAX_CELLS*gbnq_pkg::WORDS_PER_CELL];

  hit_t   pending_hits[$];
  int     mismatches = 0;
  int     gap_pct = 0;
  longint cycle_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("grid_bitset_neighbour_query_test: errors");
      $finish;
    end
  end

  // result checker: every strobed result must match the oldest expectation
  always @(posedge clk_i) begin
    hit_t want;
    if (rst_ni && valid_o) begin
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: agent %0d found %0b last %0b",
                   hit_agent_o, found_o, last_o);
      end else begin
        want = pending_hits.pop_front();
        if (want.hit_agent !== hit_agent_o || want.found !== found_o ||
            want.last !== last_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp agent %0d found %0b last %0b, got %0d %0b %0b",
                     want.hit_agent, want.found, want.last,
                     hit_agent_o, found_o, last_o);
        end
      end
    end
  end

  function automatic longint eff_res();
    if (grid_res == 0) return 1;
    if (grid_res > gbnq_pkg::MAX_CELLS) return gbnq_pkg::MAX_CELLS;
    return longint'(grid_res);
  endfunction

  // world coordinate to cell index; 0 when outside the grid
  function automatic bit cell_of(input longint pos, output longint cell_idx);
    longint span;
    span = grid_hi - grid_lo;
    cell_idx = 0;
    if (span <= 0 || pos < grid_lo || pos >= grid_hi) return 0;
    cell_idx = ((pos - grid_lo) * eff_res()) / span;
    if (cell_idx > eff_res() - 1) cell_idx = eff_res() - 1;
    return 1;
  endfunction

  // applies one accepted item to the local stores and queues its results
  task automatic predict_item(input gbnq_pkg::action_e act, input logic [7:0] agent,
                              input logic signed [31:0] px,
                              input logic signed [31:0] py,
                              input logic [30:0] rad);
    longint cx, cy, res, reach, x0, x1, y0, y1;
    int     n;
    logic [63:0] both;
    hit_t   h;
    n = 0;
    case (act)
      gbnq_pkg::ACT_CLEAR: begin
        foreach (row_bits[i]) begin
          row_bits[i] = '0;
          col_bits[i] = '0;
        end
      end
      gbnq_pkg::ACT_INSERT: begin
        if (cell_of(longint'(px), cx) && cell_of(longint'(py), cy)) begin
          row_bits[cx*gbnq_pkg::WORDS_PER_CELL + agent[7:6]][agent[5:0]] = 1'b1;
          col_bits[cy*gbnq_pkg::WORDS_PER_CELL + agent[7:6]][agent[5:0]] = 1'b1;
        end
      end
      gbnq_pkg::ACT_QUERY: begin
        if (cell_of(longint'(px), cx) && cell_of(longint'(py), cy)) begin
          res = eff_res();
          reach = (longint'(rad) * res) / (grid_hi - grid_lo);
          if (reach > res) reach = res;
          x0 = (cx - reach < 0) ? 0 : cx - reach;
          x1 = (cx + reach > res - 1) ? res - 1 : cx + reach;
          y0 = (cy - reach < 0) ? 0 : cy - reach;
          y1 = (cy + reach > res - 1) ? res - 1 : cy + reach;
          for (longint x = x0; x <= x1 && n < gbnq_pkg::MAX_HITS; x++)
            for (longint y = y0; y <= y1 && n < gbnq_pkg::MAX_HITS; y++)
              for (int w = 0; w < gbnq_pkg::WORDS_PER_CELL && n < gbnq_pkg::MAX_HITS;
                   w++) begin
                both = row_bits[x*gbnq_pkg::WORDS_PER_CELL + w] &
                       col_bits[y*gbnq_pkg::WORDS_PER_CELL + w];
                for (int b = 0; b < gbnq_pkg::WORD_BITS && n < gbnq_pkg::MAX_HITS; b++)
                  if (both[b]) begin
                    h.hit_agent = 8'(w*gbnq_pkg::WORD_BITS + b);
                    h.found = 1'b1;
                    h.last = 1'b0;
                    pending_hits.push_back(h);
                    n++;
                  end
              end
        end
        if (n == 0) begin
          h = '{hit_agent: 8'd0, found: 1'b0, last: 1'b1};
          pending_hits.push_back(h);
        end else begin
          pending_hits[pending_hits.size()-1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // drives one item, waits for its transfer; start stays high unless a gap follows
  task automatic send_item(input gbnq_pkg::action_e act, input logic [7:0] agent,
                           input logic signed [31:0] px,
                           input logic signed [31:0] py,
                           input logic [30:0] rad);
    start <= 1'b1;
    action_i <= act;
    agent_index_i <= agent;
    pos_x_i <= px;
    pos_y_i <= py;
    radius_i <= rad;
    do @(posedge clk_i); while (busy);
    predict_item(act, agent, px, py, rad);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // stops issuing and waits until the block is idle with nothing outstanding
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic cfg_write(input gbnq_pkg::cfg_idx_e idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      gbnq_pkg::CFG_RANGE_LOW:  grid_lo = longint'(signed'(data));
      gbnq_pkg::CFG_RANGE_HIGH: grid_hi = longint'(signed'(data));
      default:                  grid_res = data[6:0];
    endcase
  endtask

  // a coordinate, mostly inside the grid, sometimes anywhere
  function automatic logic [31:0] pick_pos();
    longint span;
    span = grid_hi - grid_lo;
    if (span > 0 && $urandom_range(99) < 85)
      return 32'(grid_lo + longint'({$urandom, $urandom}) % span);
    return $urandom;
  endfunction

  // radius: mostly zero to three cells plus up to 65535, rarely any 31-bit value
  function automatic logic [30:0] pick_radius();
    longint span;
    span = grid_hi - grid_lo;
    if ($urandom_range(99) < 4 || span <= 0) return 31'($urandom);
    return 31'((span / eff_res()) * $urandom_range(0, 3) + $urandom_range(0, 65535));
  endfunction

  task automatic random_items(input int count);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 3)
        send_item(gbnq_pkg::ACT_CLEAR, 8'($urandom), $urandom, $urandom, 31'($urandom));
      else if (roll < 7)
        send_item(gbnq_pkg::ACT_NOP, 8'($urandom), $urandom, $urandom, 31'($urandom));
      else if (roll < 57)
        send_item(gbnq_pkg::ACT_INSERT, 8'($urandom), pick_pos(), pick_pos(),
                  31'($urandom));
      else
        send_item(gbnq_pkg::ACT_QUERY, 8'($urandom), pick_pos(), pick_pos(),
                  pick_radius());
    end
  endtask

  // edges of the field, agent extremes, outside inserts and the hit cap
  task automatic test_directed();
    send_item(gbnq_pkg::ACT_QUERY, 8'd0, 32'sd0, 32'sd0, 31'd0);
    send_item(gbnq_pkg::ACT_INSERT, 8'd0, 32'sd0, 32'sd0, 31'd0);
    send_item(gbnq_pkg::ACT_INSERT, 8'd255, 32'sh003F_FFFF, 32'sh003F_FFFF, 31'h7FFF_FFFF);
    send_item(gbnq_pkg::ACT_INSERT, 8'd63, 32'sh0040_0000, 32'sd0, 31'd0);
    send_item(gbnq_pkg::ACT_INSERT, 8'd64, -32'sd1, 32'sd5, 31'd0);
    send_item(gbnq_pkg::ACT_INSERT, 8'd128, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'd0);
    send_item(gbnq_pkg::ACT_NOP, 8'hFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF);
    send_item(gbnq_pkg::ACT_QUERY, 8'd0, 32'sd0, 32'sd0, 31'd0);
    send_item(gbnq_pkg::ACT_QUERY, 8'd0, 32'sh003F_FFFF, 32'sh003F_FFFF, 31'd0);
    send_item(gbnq_pkg::ACT_QUERY, 8'd0, 32'sh0020_0000, 32'sh0020_0000, 31'h7FFF_FFFF);
    send_item(gbnq_pkg::ACT_QUERY, 8'd0, 32'sh0040_0000, 32'sd0, 31'h7FFF_FFFF);
    // more than the hit cap in one cell
    for (int a = 0; a < 18; a++)
      send_item(gbnq_pkg::ACT_INSERT, 8'(a * 13 + 1), 32'sh0010_0000, 32'sh0010_0000,
                31'd0);
    send_item(gbnq_pkg::ACT_QUERY, 8'd0, 32'sh0010_0000, 32'sh0010_0000, 31'd0);
    send_item(gbnq_pkg::ACT_CLEAR, 8'd0, 32'sd0, 32'sd0, 31'd0);
    send_item(gbnq_pkg::ACT_QUERY, 8'd0, 32'sh0010_0000, 32'sh0010_0000, 31'h7FFF_FFFF);
    drain();
  endtask

  task automatic config_phase(input logic [31:0] lo, input logic [31:0] hi,
                              input logic [6:0] res, input int count);
    cfg_write(gbnq_pkg::CFG_RANGE_LOW, lo);
    cfg_write(gbnq_pkg::CFG_RANGE_HIGH, hi);
    cfg_write(gbnq_pkg::CFG_RESOLUTION, {25'd0, res});
    random_items(count);
    drain();
  endtask

  // walks through resolution and range extremes, reversed range included
  task automatic test_settings();
    config_phase(32'hFFF0_0000, 32'h0010_0000, 7'd1, 18);
    config_phase(32'h0000_0000, 32'h0001_0000, 7'd0, 18);
    config_phase(32'h8000_0000, 32'h7FFF_FFFF, 7'd127, 18);
    config_phase(32'h0010_0000, 32'h0010_0000, 7'd8, 12);
    config_phase(32'h0020_0000, 32'h0010_0000, 7'd8, 12);
    config_phase(32'hFFC0_0000, 32'h0000_0000, 7'd5, 18);
    config_phase(32'h0000_0000, 32'h0040_0000, 7'd16, 18);
  endtask

  // sender idling after 35 percent of items, then after 62 percent, then never
  task automatic test_random_traffic();
    gap_pct = 35;
    random_items(30);
    drain();
    gap_pct = 62;
    random_items(30);
    drain();
    gap_pct = 0;
    random_items(30);
    drain();
  endtask

  initial begin
    grid_lo = 0;
    grid_hi = 4194304;
    grid_res = 7'd64;
    foreach (row_bits[i]) begin
      row_bits[i] = '0;
      col_bits[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gap_pct = 35;
    test_directed();
    test_settings();
    test_random_traffic();
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("grid_bitset_neighbour_query_test: clean");
    end else begin
      $display("grid_bitset_neighbour_query_test: errors");
    end
    $finish;
  end

endmodule
